[rtl/core/assert_macros.svh]
// Assertion helpers for the RTL. Each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication.
`define RSE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define RSE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define RSE_ASSERT_IMP(lbl, ante, cons)
`define RSE_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

[rtl/core/rse_pkg.sv]
package rse_pkg;

  localparam int DATA_W  = 32;
  localparam int COUNT_W = 7;
  localparam int FUNC_W  = 3;
  localparam int STAT_W  = 3;

  localparam logic [FUNC_W-1:0] FUNC_PUSH   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD    = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_SUB    = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_MUL    = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_DIV    = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_FINISH = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_UNDER   = 3'd1;
  localparam logic [STAT_W-1:0] ST_DIVZERO = 3'd2;
  localparam logic [STAT_W-1:0] ST_BADOP   = 3'd3;
  localparam logic [STAT_W-1:0] ST_OVER    = 3'd4;
  localparam logic [STAT_W-1:0] ST_NOTONE  = 3'd5;
  localparam logic [STAT_W-1:0] ST_SAT     = 3'd6;

  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic signed [DATA_W-1:0] operand_value;
  } rse_in_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] top_value;
    logic [COUNT_W-1:0]       stack_count;
    logic                     finished;
  } rse_out_t;

endpackage

[rtl/core/rpn_stack_evaluator_core.sv]
// Reverse Polish evaluator on signed fixed-point values. Raise start with an item
// while busy is low; every item gives exactly one result on out_item, marked by
// out_valid for one cycle, and the receiver cannot stall it. Push, finish, error
// and ignored items answer in the next cycle; add and subtract after one stack
// memory read; multiply after a registered 32x32 product, then shift and clamp;
// divide after a memory read, a 32-step restoring divider, scale and clamp (or
// straight after the memory read when the right operand is zero). The top of
// stack sits in a register, the rest in a one-port synchronous memory. Busy is
// low again in the cycle the result shows, so the next item may enter then.
`include "assert_macros.svh"

module rpn_stack_evaluator_core import rse_pkg::*; #(
  parameter int STACK_DEPTH   = 64,
  parameter int FRACTION_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  rse_in_t  in_item,
  output logic     busy,
  output logic     out_valid,
  output rse_out_t out_item
);

  localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int CW  = $clog2(DATA_W);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DFIN = 3'd4;

  logic [2:0]               state_r, state_nxt;
  logic [SPW-1:0]           sp_r, sp_nxt;
  logic [STAT_W-1:0]        sticky_r, sticky_nxt;
  logic signed [DATA_W-1:0] top_r, top_nxt;
  logic [FUNC_W-1:0]        func_r, func_nxt;
  logic                     out_valid_r, out_valid_nxt;
  rse_out_t                 out_r, out_nxt;

  logic signed [DATA_W-1:0]   mem [STACK_DEPTH];
  logic signed [DATA_W-1:0]   rdata_r;
  logic                       wr_en, rd_en;
  logic [SPW-1:0]             spm1, spm2;

  logic signed [2*DATA_W-1:0] prod_r, prod_nxt, prod_sh;
  logic [DATA_W-1:0]          rem_r, rem_nxt, quo_r, quo_nxt, dvs_r, dvs_nxt;
  logic                       neg_r, neg_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic [DATA_W:0]            div_sh, div_diff;
  logic [2*DATA_W-1:0]        scaled;
  logic signed [DATA_W:0]     sum;
  logic signed [DATA_W-1:0]   topz, op_a;

  assign spm1 = sp_r - SPW'(1);
  assign spm2 = sp_r - SPW'(2);
  assign topz = (sp_r == '0) ? '0 : top_r;
  assign op_a = rdata_r;

  assign div_sh   = {rem_r, quo_r[DATA_W-1]};
  assign div_diff = div_sh - {1'b0, dvs_r};
  assign prod_sh  = prod_r >>> FRACTION_BITS;
  assign scaled   = {{DATA_W{1'b0}}, quo_r} << FRACTION_BITS;

  always_comb begin
    state_nxt     = state_r;
    sp_nxt        = sp_r;
    sticky_nxt    = sticky_r;
    top_nxt       = top_r;
    func_nxt      = func_r;
    prod_nxt      = prod_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    dvs_nxt       = dvs_r;
    neg_nxt       = neg_r;
    cnt_nxt       = cnt_r;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    sum           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          out_valid_nxt    = 1'b1;
          out_nxt.finished = 1'b0;
          out_nxt.status   = sticky_r;
          out_nxt.top_value = topz;
          priority if (in_item.func == FUNC_FINISH) begin
            out_nxt.finished  = 1'b1;
            out_nxt.top_value = '0;
            if (sticky_r == ST_OK) begin
              if (sp_r == SPW'(1)) begin
                out_nxt.status    = ST_OK;
                out_nxt.top_value = top_r;
              end else begin
                out_nxt.status = ST_NOTONE;
              end
            end
            sp_nxt     = '0;
            sticky_nxt = ST_OK;
          end else if (sticky_r != ST_OK) begin
            // ignore the item, report the held error
          end else if (in_item.func == FUNC_PUSH) begin
            if (sp_r >= SPW'(STACK_DEPTH)) begin
              sticky_nxt     = ST_OVER;
              out_nxt.status = ST_OVER;
            end else begin
              wr_en             = (sp_r != '0);
              top_nxt           = in_item.operand_value;
              sp_nxt            = sp_r + SPW'(1);
              out_nxt.status    = ST_OK;
              out_nxt.top_value = in_item.operand_value;
            end
          end else if (in_item.func > FUNC_FINISH) begin
            sticky_nxt     = ST_BADOP;
            out_nxt.status = ST_BADOP;
          end else if (sp_r < SPW'(2)) begin
            sticky_nxt     = ST_UNDER;
            out_nxt.status = ST_UNDER;
          end else begin
            // fetch the left operand; the right one is the top register
            out_valid_nxt = 1'b0;
            rd_en         = 1'b1;
            func_nxt      = in_item.func;
            state_nxt     = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        unique case (func_r)
          FUNC_ADD, FUNC_SUB: begin
            sum = (func_r == FUNC_ADD) ? ({op_a[DATA_W-1], op_a} + {top_r[DATA_W-1], top_r})
                                       : ({op_a[DATA_W-1], op_a} - {top_r[DATA_W-1], top_r});
            out_valid_nxt    = 1'b1;
            out_nxt.finished = 1'b0;
            sp_nxt           = spm1;
            if (sum[DATA_W] != sum[DATA_W-1]) begin
              top_nxt        = sum[DATA_W] ? VAL_MIN : VAL_MAX;
              out_nxt.status = ST_SAT;
            end else begin
              top_nxt        = sum[DATA_W-1:0];
              out_nxt.status = ST_OK;
            end
            out_nxt.top_value = top_nxt;
            state_nxt         = S_IDLE;
          end
          FUNC_MUL: begin
            prod_nxt  = op_a * top_r;
            state_nxt = S_MUL;
          end
          default: begin
            if (top_r == '0) begin
              sticky_nxt        = ST_DIVZERO;
              out_valid_nxt     = 1'b1;
              out_nxt.finished  = 1'b0;
              out_nxt.status    = ST_DIVZERO;
              out_nxt.top_value = top_r;
              state_nxt         = S_IDLE;
            end else begin
              rem_nxt   = '0;
              quo_nxt   = op_a[DATA_W-1] ? -op_a : op_a;
              dvs_nxt   = top_r[DATA_W-1] ? -top_r : top_r;
              neg_nxt   = op_a[DATA_W-1] ^ top_r[DATA_W-1];
              cnt_nxt   = '0;
              state_nxt = S_DIV;
            end
          end
        endcase
      end
      S_MUL: begin
        out_valid_nxt    = 1'b1;
        out_nxt.finished = 1'b0;
        sp_nxt           = spm1;
        if (prod_sh > 64'(VAL_MAX)) begin
          top_nxt        = VAL_MAX;
          out_nxt.status = ST_SAT;
        end else if (prod_sh < 64'(VAL_MIN)) begin
          top_nxt        = VAL_MIN;
          out_nxt.status = ST_SAT;
        end else begin
          top_nxt        = prod_sh[DATA_W-1:0];
          out_nxt.status = ST_OK;
        end
        out_nxt.top_value = top_nxt;
        state_nxt         = S_IDLE;
      end
      S_DIV: begin
        if (!div_diff[DATA_W]) begin
          rem_nxt = div_diff[DATA_W-1:0];
        end else begin
          rem_nxt = div_sh[DATA_W-1:0];
        end
        quo_nxt = {quo_r[DATA_W-2:0], ~div_diff[DATA_W]};
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(DATA_W - 1)) begin
          state_nxt = S_DFIN;
        end
      end
      S_DFIN: begin
        out_valid_nxt    = 1'b1;
        out_nxt.finished = 1'b0;
        sp_nxt           = spm1;
        if (!neg_r && scaled > 64'h0000_0000_7FFF_FFFF) begin
          top_nxt        = VAL_MAX;
          out_nxt.status = ST_SAT;
        end else if (neg_r && scaled > 64'h0000_0000_8000_0000) begin
          top_nxt        = VAL_MIN;
          out_nxt.status = ST_SAT;
        end else begin
          top_nxt        = neg_r ? -scaled[DATA_W-1:0] : scaled[DATA_W-1:0];
          out_nxt.status = ST_OK;
        end
        out_nxt.top_value = top_nxt;
        state_nxt         = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_nxt.stack_count = COUNT_W'(sp_nxt);
  end

  // stack memory: entries below the top register
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[spm1[AW-1:0]] <= top_r;
    end
    if (rd_en) begin
      rdata_r <= mem[spm2[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sp_r        <= '0;
      sticky_r    <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sp_r        <= sp_nxt;
      sticky_r    <= sticky_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r  <= top_nxt;
    func_r <= func_nxt;
    out_r  <= out_nxt;
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dvs_r  <= dvs_nxt;
    neg_r  <= neg_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `RSE_ASSERT_IMP(a_sp_bound, 1'b1, sp_r <= SPW'(STACK_DEPTH))
  `RSE_ASSERT_NXT(a_item_answered, start && !busy, busy || out_valid)
  `RSE_ASSERT_IMP(a_finish_empties, out_valid && out_item.finished, out_item.stack_count == '0)
  `RSE_ASSERT_IMP(a_op_has_operands, state_r != S_IDLE, sp_r >= SPW'(2))

endmodule

[test/rpn_stack_evaluator_checker.sv]
`timescale 1ns / 100ps

module rpn_stack_evaluator_checker import rse_pkg::*; #(
  parameter int STACK_DEPTH   = 64,
  parameter int FRACTION_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     busy,
  input  rse_in_t  in_item,
  input  logic     out_valid,
  input  rse_out_t out_item,
  output int       fail_count,
  output int       pending
);

  logic signed [DATA_W-1:0] eval_stack [STACK_DEPTH];
  int unsigned              depth;
  logic [STAT_W-1:0]        sticky;
  rse_out_t                 answer_q [$];

  function automatic logic signed [DATA_W-1:0] clamp_value(input logic signed [65:0] v,
                                                           inout logic sat);
    if (v > 66'sd2147483647) begin
      sat = 1'b1;
      return VAL_MAX;
    end
    if (v < -66'sd2147483648) begin
      sat = 1'b1;
      return VAL_MIN;
    end
    return v[DATA_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] top_now();
    return (depth == 0) ? '0 : eval_stack[depth-1];
  endfunction

  function automatic rse_out_t evaluate_token(input rse_in_t tok);
    rse_out_t                 res;
    logic signed [65:0]       a, b, wide;
    logic signed [DATA_W-1:0] r;
    logic                     sat;
    sat = 1'b0;
    res = '0;
    if (tok.func == FUNC_FINISH) begin
      res.status = sticky;
      if (sticky == ST_OK) begin
        if (depth == 1) res.top_value = eval_stack[0];
        else res.status = ST_NOTONE;
      end
      res.finished = 1'b1;
      depth = 0;
      sticky = ST_OK;
      return res;
    end
    if (sticky != ST_OK) begin
      res.status = sticky;
    end else if (tok.func == FUNC_PUSH) begin
      if (depth >= STACK_DEPTH) begin
        sticky = ST_OVER;
      end else begin
        eval_stack[depth] = tok.operand_value;
        depth++;
      end
    end else if (tok.func > FUNC_FINISH) begin
      sticky = ST_BADOP;
    end else if (depth < 2) begin
      sticky = ST_UNDER;
    end else begin
      b = eval_stack[depth-1];
      a = eval_stack[depth-2];
      case (tok.func)
        FUNC_ADD: r = clamp_value(a + b, sat);
        FUNC_SUB: r = clamp_value(a - b, sat);
        FUNC_MUL: r = clamp_value((a * b) >>> FRACTION_BITS, sat);
        default: begin
          if (b == 0) sticky = ST_DIVZERO;
          else begin
            wide = a / b;
            r = clamp_value(wide <<< FRACTION_BITS, sat);
          end
        end
      endcase
      if (sticky == ST_OK) begin
        depth--;
        eval_stack[depth-1] = r;
      end
    end
    if (res.status == ST_OK) res.status = (sticky != ST_OK) ? sticky : (sat ? ST_SAT : ST_OK);
    res.top_value   = top_now();
    res.stack_count = depth[COUNT_W-1:0];
    return res;
  endfunction

  assign pending = answer_q.size();

  always @(posedge clk) begin
    rse_out_t want;
    if (!rst_n) begin
      depth = 0;
      sticky = ST_OK;
      fail_count <= 0;
      answer_q.delete();
    end else begin
      if (out_valid) begin
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_item);
          fail_count <= fail_count + 1;
        end else begin
          want = answer_q.pop_front();
          if (out_item !== want) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, out_item);
            fail_count <= fail_count + 1;
          end
        end
      end
      // pop before push: a result and a new item can land on the same edge
      if (start && !busy) answer_q.push_back(evaluate_token(in_item));
    end
  end

endmodule

[test/rpn_stack_evaluator_core_tb.sv]
`timescale 1ns / 100ps

module rpn_stack_evaluator_core_tb import rse_pkg::*;;

  localparam int RANDOM_ITEMS = 1650;
  localparam int WATCHDOG     = 2000;

  logic     clk;
  logic     rst_n;
  logic     start;
  rse_in_t  in_item;
  logic     busy;
  logic     out_valid;
  rse_out_t out_item;
  int       fail_count;
  int       pending;
  int       idle_cycles = 0;
  logic     timed_out = 1'b0;
  int       issued = 0;

  rpn_stack_evaluator_core u_top (
    .clk, .rst_n, .start, .in_item, .busy, .out_valid, .out_item
  );

  rpn_stack_evaluator_checker u_checker (
    .clk, .rst_n, .start, .busy, .in_item, .out_valid, .out_item, .fail_count, .pending
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) timed_out <= 1'b1;
  end

  initial begin
    wait (timed_out === 1'b1);
    $display("FAILURE");
    $finish;
  end

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return 0;
      3: return $signed($urandom_range(0, 8) << 16) - 32'sh40000;
      4: return $signed($urandom_range(0, 255) << 16);
      default: return $urandom();
    endcase
  endfunction

  task automatic issue_token(input logic [FUNC_W-1:0] f, input logic signed [DATA_W-1:0] v,
                             input bit allow_gap);
    if (allow_gap && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= '{func: f, operand_value: v};
    @(posedge clk);
    while (busy) @(posedge clk);
    issued++;
  endtask

  task automatic run_expression(input bit allow_gap);
    int n;
    int ops;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 66) : $urandom_range(1, 6);
    issue_token(FUNC_PUSH, pick_value(), allow_gap);
    for (int i = 1; i < n; i++) begin
      issue_token(FUNC_PUSH, pick_value(), allow_gap);
      if (n < 10 && $urandom_range(0, 1)) begin
        issue_token(FUNC_W'($urandom_range(1, 4)), 0, allow_gap);
      end
    end
    ops = n + $urandom_range(0, 2) - 1;
    for (int i = 0; i < ops; i++) begin
      // noise: rare bad ops among the arithmetic items
      if ($urandom_range(0, 30) == 0) begin
        issue_token(FUNC_W'($urandom_range(6, 7)), $urandom(), allow_gap);
      end else begin
        issue_token(FUNC_W'($urandom_range(1, 4)), $urandom(), allow_gap);
      end
    end
    issue_token(FUNC_FINISH, $urandom(), allow_gap);
  endtask

  initial begin
    bit paused;
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_item <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, every op, each fault
    issue_token(FUNC_PUSH, VAL_MAX, 0);
    issue_token(FUNC_PUSH, VAL_MAX, 0);
    issue_token(FUNC_ADD, 0, 0);
    issue_token(FUNC_PUSH, VAL_MIN, 0);
    issue_token(FUNC_SUB, 0, 0);
    issue_token(FUNC_FINISH, 0, 0);
    issue_token(FUNC_PUSH, VAL_MIN, 0);
    issue_token(FUNC_PUSH, -32'sd65536, 0);
    issue_token(FUNC_DIV, 0, 0);
    issue_token(FUNC_PUSH, VAL_MIN, 0);
    issue_token(FUNC_MUL, 0, 0);
    issue_token(FUNC_FINISH, 0, 0);
    issue_token(FUNC_ADD, 0, 0);
    issue_token(FUNC_PUSH, 5, 0);
    issue_token(FUNC_FINISH, 0, 0);
    issue_token(FUNC_PUSH, 7, 0);
    issue_token(FUNC_PUSH, 0, 0);
    issue_token(FUNC_DIV, 0, 0);
    issue_token(FUNC_FINISH, 0, 0);
    issue_token(3'd6, 0, 0);
    issue_token(FUNC_FINISH, 0, 0);
    issue_token(3'd7, 0, 0);
    issue_token(FUNC_FINISH, 0, 0);
    issue_token(FUNC_FINISH, 0, 0);
    for (int i = 0; i < STACK_DEPTH_TB(); i++) issue_token(FUNC_PUSH, $urandom(), 0);
    issue_token(FUNC_FINISH, 0, 0);

    paused = 1'b0;
    while (issued < RANDOM_ITEMS) begin
      run_expression(issued < RANDOM_ITEMS * 3 / 4);
      if (!paused && issued > RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
    end
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  function automatic int STACK_DEPTH_TB();
    return 65;
  endfunction

endmodule

[files.f]
+incdir+rtl/core
rtl/core/rse_pkg.sv
rtl/core/rpn_stack_evaluator_core.sv
test/rpn_stack_evaluator_checker.sv
test/rpn_stack_evaluator_core_tb.sv
